[rtl/core/dnsar_pkg.sv]
// ----------------------------------------------------------------------------
// dnsar_pkg
// shared types and constants of the dns a-record responder
// ----------------------------------------------------------------------------
package dnsar_pkg;

  localparam int MAX_MESSAGE_DEF = 1024;  // default message room in bytes
  localparam int HDR_LEN         = 12;    // dns header length
  localparam int REC_LEN         = 16;    // answer record length
  localparam int TAIL_LEN        = 4;     // qtype and qclass
  localparam int CMD_DEPTH       = 4;     // entries between front and back

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_TAIL,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_RESPONSE,
    ST_OPCODE,
    ST_TRUNC,
    ST_SHORT,
    ST_COMPRESSED,
    ST_NAME,
    ST_ROOM
  } status_t;

  typedef enum logic [1:0] {
    CMD_BYTE,     // one reply byte
    CMD_STATUS,   // end of message with an error status
    CMD_RECORD    // optional lead byte, then the answer record
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        lead;
    logic [7:0]  data;
    status_t     st;
  } cmd_t;

endpackage

[rtl/core/dnsar_front.sv]
// ----------------------------------------------------------------------------
// dnsar_front
// query parser: checks the header, walks the first name, issues commands
// ----------------------------------------------------------------------------
module dnsar_front import dnsar_pkg::*; #(
  parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  localparam int POS_W = $clog2(MAX_MESSAGE + 1);
  localparam int SUM_W = $clog2(MAX_MESSAGE + 258);

  logic [POS_W-1:0] pos, pos_next;
  phase_t           phase, phase_next;
  logic [7:0]       label_left, label_left_next;
  logic [POS_W-1:0] name_len, name_len_next;
  logic [2:0]       tail_left, tail_left_next;
  status_t          err, err_next;

  logic             in_room;
  logic             have;
  logic [7:0]       ob;
  logic             fail_hit;
  status_t          fail_code;
  logic [SUM_W-1:0] room_sum;
  logic [POS_W-1:0] pos_inc;

  assign in_room  = pos < POS_W'(MAX_MESSAGE);
  assign pos_inc  = pos + POS_W'(1);
  assign room_sum = SUM_W'(name_len) + SUM_W'(in_byte) + SUM_W'(2);

  always_comb begin
    pos_next        = pos;
    phase_next      = phase;
    label_left_next = label_left;
    name_len_next   = name_len;
    tail_left_next  = tail_left;
    err_next        = err;
    have            = 1'b0;
    ob              = in_byte;
    fail_hit        = 1'b0;
    fail_code       = ST_OK;
    cmd_valid       = 1'b0;
    cmd             = '{kind: CMD_BYTE, lead: 1'b0, data: 8'h00, st: ST_OK};

    if (in_room) begin
      pos_next = pos_inc;
      case (phase)
        PH_HEADER: begin
          have = 1'b1;
          if (pos == POS_W'(2)) begin
            if (in_byte[7]) begin
              fail_hit  = 1'b1;
              fail_code = ST_RESPONSE;
            end else if (in_byte[6:3] != 4'h0) begin
              fail_hit  = 1'b1;
              fail_code = ST_OPCODE;
            end else if (in_byte[1]) begin
              fail_hit  = 1'b1;
              fail_code = ST_TRUNC;
            end else begin
              ob = in_byte | 8'h84;  // qr and aa
            end
          end else if (pos == POS_W'(3)) begin
            ob = in_byte | 8'h80;    // ra
          end else if (pos >= POS_W'(4)) begin
            // one question, one answer, no other records
            ob = (pos == POS_W'(5) || pos == POS_W'(7)) ? 8'h01 : 8'h00;
          end
          if (pos_inc >= POS_W'(HDR_LEN)) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (in_byte[7:6] != 2'b00) begin
            fail_hit  = 1'b1;
            fail_code = ST_COMPRESSED;
          end else if (in_byte == 8'h00) begin
            have           = 1'b1;
            tail_left_next = 3'(TAIL_LEN);
            phase_next     = PH_TAIL;
          end else if (room_sum >= SUM_W'(MAX_MESSAGE - 1)) begin
            fail_hit  = 1'b1;
            fail_code = ST_NAME;
          end else begin
            have            = 1'b1;
            name_len_next   = name_len + POS_W'(name_len != '0) + POS_W'(in_byte);
            label_left_next = in_byte;
            phase_next      = PH_LABEL;
          end
        end
        PH_LABEL: begin
          have            = 1'b1;
          label_left_next = label_left - 8'd1;
          if (label_left == 8'd1) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_TAIL: begin
          have           = 1'b1;
          tail_left_next = tail_left - 3'd1;
          if (tail_left == 3'd1) begin
            if (pos_inc > POS_W'(MAX_MESSAGE - REC_LEN)) begin
              fail_hit  = 1'b1;
              fail_code = ST_ROOM;
            end else begin
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (fail_hit) begin
      have       = 1'b0;
      phase_next = PH_ERROR;
      err_next   = fail_code;
    end

    if (in_last) begin
      // message ends before the question is complete
      if (phase_next == PH_HEADER) begin
        phase_next = PH_ERROR;
        err_next   = ST_SHORT;
      end else if (phase_next != PH_DONE && phase_next != PH_ERROR) begin
        phase_next = PH_ERROR;
        err_next   = ST_NAME;
      end
      cmd_valid = 1'b1;
      if (phase_next == PH_ERROR) begin
        cmd = '{kind: CMD_STATUS, lead: 1'b0, data: 8'h00, st: err_next};
      end else begin
        cmd = '{kind: CMD_RECORD, lead: have, data: ob, st: ST_OK};
      end
      pos_next        = '0;
      phase_next      = PH_HEADER;
      label_left_next = '0;
      name_len_next   = '0;
      tail_left_next  = '0;
      err_next        = ST_OK;
    end else begin
      cmd_valid = have;
      cmd       = '{kind: CMD_BYTE, lead: 1'b0, data: ob, st: ST_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      phase      <= PH_HEADER;
      label_left <= '0;
      name_len   <= '0;
      tail_left  <= '0;
      err        <= ST_OK;
    end else if (accept) begin
      pos        <= pos_next;
      phase      <= phase_next;
      label_left <= label_left_next;
      name_len   <= name_len_next;
      tail_left  <= tail_left_next;
      err        <= err_next;
    end
  end

  a_label_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LABEL |-> label_left != 8'd0)
    else $error("label phase with no label bytes left");

  a_tail_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TAIL |-> (tail_left != 3'd0 && tail_left <= 3'(TAIL_LEN)))
    else $error("tail counter out of range");

endmodule

[rtl/core/dnsar_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// dnsar_cmd_fifo
// short command queue between the parser and the reply sequencer
// ----------------------------------------------------------------------------
module dnsar_cmd_fifo import dnsar_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(CMD_DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command written while queue full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("command read while queue empty");

endmodule

[rtl/core/dnsar_back.sv]
// ----------------------------------------------------------------------------
// dnsar_back
// reply sequencer: expands commands into words on the output register
// ----------------------------------------------------------------------------
module dnsar_back import dnsar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        head_pop,
  input  logic [31:0] answer_ttl,
  input  logic [31:0] answer_address,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        out_last,
  output logic [2:0]  status
);

  localparam int CNT_W = $clog2(REC_LEN + 2);

  function automatic logic [7:0] rec_byte(input logic [3:0] idx,
                                          input logic [31:0] ttl,
                                          input logic [31:0] addr);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hC0;             // name pointer
      4'd1:    b = 8'(HDR_LEN);
      4'd3:    b = 8'h01;             // type a
      4'd5:    b = 8'h01;             // class in
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd11:   b = 8'h04;             // rdlength
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  logic             out_valid;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [3:0]       ridx;
  logic             load;
  logic [7:0]       nb;
  logic             nv, nl;
  status_t          ns;

  assign empty = !out_valid;
  assign load  = head_valid && (!out_valid || pop);
  assign ridx  = 4'(cnt - CNT_W'(head.lead));

  always_comb begin
    head_pop = 1'b0;
    cnt_next = cnt;
    nb       = 8'h00;
    nv       = 1'b0;
    nl       = 1'b0;
    ns       = ST_OK;
    case (head.kind)
      CMD_BYTE: begin
        nb       = head.data;
        nv       = 1'b1;
        head_pop = load;
      end
      CMD_STATUS: begin
        nl       = 1'b1;
        ns       = head.st;
        head_pop = load;
      end
      CMD_RECORD: begin
        nv = 1'b1;
        if (head.lead && cnt == '0) begin
          nb = head.data;
          if (load) begin
            cnt_next = CNT_W'(1);
          end
        end else begin
          nb = rec_byte(ridx, answer_ttl, answer_address);
          nl = ridx == 4'(REC_LEN - 1);
          if (load) begin
            if (nl) begin
              head_pop = 1'b1;
              cnt_next = '0;
            end else begin
              cnt_next = cnt + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        head_pop = load;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      cnt <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= nb;
      byte_valid <= nv;
      out_last   <= nl;
      status     <= 3'(ns);
    end
  end

  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (out_last && status != 3'(ST_OK)))
    else $error("word without a byte is not an error status");

  a_record_busy: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> (head_valid && head.kind == CMD_RECORD))
    else $error("record counter running without a record command");

endmodule

[rtl/core/dns_fixed_a_record_responder.sv]
// ----------------------------------------------------------------------------
// dns_fixed_a_record_responder
// streams a dns reply with one fixed a record from a query byte stream
// ----------------------------------------------------------------------------
// usage
//   input queue: a query word (in_byte, in_last) is taken at a clock edge
//   with push high and full low; in_last marks the final query byte
//   output queue: the oldest reply word sits on out_byte, byte_valid,
//   out_last and status while empty is low and leaves on an edge with pop
//   config: wr_en writes wr_data to answer_ttl (index 0) or answer_address
//   (index 1); unenforced: the user must write only while the block is idle
// timing
//   a pushed word is written into the command queue and then loaded into
//   the output register; one query byte per cycle while full stays low;
//   the final byte of a good query expands into an optional lead byte and
//   the 16-byte answer record, which the sequencer plays out at one word
//   per cycle while pop keeps up and the command queue fills and then
//   stalls input through full; a stalled consumer backs up the output
//   register, then the command queue, then full rises
// reset
//   rst clears the parser, the queue and the output valid flag; the output
//   word is not reset, and answer_ttl and answer_address return to zero
// ----------------------------------------------------------------------------
module dns_fixed_a_record_responder import dnsar_pkg::*; #(
  parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // query words
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // reply words
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        out_last,
  output logic [2:0]  status,
  // configuration writes
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data
);

  localparam logic REG_TTL  = 1'b0;
  localparam logic REG_ADDR = 1'b1;

  logic [31:0] answer_ttl;
  logic [31:0] answer_address;

  logic        accept;
  logic        front_valid;
  cmd_t        front_cmd;
  logic        head_valid;
  logic        q_empty;
  cmd_t        head;
  logic        head_pop;

  // a query word is taken whenever the command queue has room
  assign accept     = push && !full;
  assign head_valid = !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_ttl     <= '0;
      answer_address <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TTL:  answer_ttl     <= wr_data;
        REG_ADDR: answer_address <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // parser: header checks and name walk, one command per query word at most
  dnsar_front #(
    .MAX_MESSAGE(MAX_MESSAGE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd_valid(front_valid),
    .cmd      (front_cmd)
  );

  // decouples the parser from the record playout
  dnsar_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (accept && front_valid),
    .wr_cmd(front_cmd),
    .full  (full),
    .rd_en (head_pop),
    .rd_cmd(head),
    .empty (q_empty)
  );

  // sequencer: turns commands into reply words
  dnsar_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop),
    .answer_ttl    (answer_ttl),
    .answer_address(answer_address),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .out_last      (out_last),
    .status        (status)
  );

endmodule
